@@ rtl/sfdp_pkg.sv @@
// Shared types and constants for the SFDP basic parameter table decoder.
package sfdp_pkg;

    localparam int unsigned MAX_ERASE_LOG2 = 16;
    localparam int unsigned DEFAULT_LOG2   = 16;
    localparam int unsigned EXP_W          =
        $clog2(((MAX_ERASE_LOG2 > DEFAULT_LOG2) ? MAX_ERASE_LOG2 : DEFAULT_LOG2) + 1);
    localparam int unsigned BLK_W          = 17;

    localparam logic [15:0] ID_BASIC       = 16'hFF00;
    localparam logic [15:0] ID_FOURBYTE    = 16'hFF84;
    localparam logic [31:0] SIZE_16MIB     = 32'(16 * 1024 * 1024);
    localparam logic [7:0]  DEFAULT_OPCODE = 8'hD8;
    localparam logic [2:0]  ADDR_3BYTE     = 3'd3;
    localparam logic [2:0]  ADDR_4BYTE     = 3'd4;

    localparam logic [1:0]  AM_3ONLY       = 2'd0;
    localparam logic [1:0]  AM_3OR4        = 2'd1;
    localparam logic [1:0]  AM_4ONLY       = 2'd2;

    localparam logic [3:0]  POS_ADDR_MODE  = 4'd0;
    localparam logic [3:0]  POS_DENSITY    = 4'd1;
    localparam logic [3:0]  POS_SECTOR_LO  = 4'd7;
    localparam logic [3:0]  POS_SECTOR_HI  = 4'd8;
    localparam logic [3:0]  POS_ENTER_4B   = 4'd15;

    localparam logic [7:0]  LEN_SECTORS    = 8'd9;
    localparam logic [7:0]  LEN_ENTER_4B   = 8'd16;
    localparam logic [7:0]  VER_MAJOR_1    = 8'd1;
    localparam logic [7:0]  VER_MINOR_4B   = 8'd5;

    typedef enum logic [1:0] {
        ST_SECTOR    = 2'd0,
        ST_NO_SECTOR = 2'd1,
        ST_FOURBYTE  = 2'd2,
        ST_UNKNOWN   = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] table_id;
        logic [7:0]  ver_major;
        logic [7:0]  ver_minor;
        logic [7:0]  len_dwords;
        logic [3:0]  position;
        logic [31:0] word;
        logic        last;
    } t_item;

    // Decoder state; erase and candidate sizes are kept as log2 exponents.
    typedef struct packed {
        logic [2:0]       addr_len;
        logic [31:0]      capacity;
        logic [EXP_W-1:0] erase_exp;
        logic [7:0]       erase_op;
        logic [EXP_W-1:0] best_exp;
        logic [7:0]       best_op;
        logic [7:0]       entry_mode;
    } t_state;

endpackage

@@ rtl/sfdp_basic_table_decoder_unit.sv @@
// Top level of the SFDP basic parameter table decoder.
// o_out_valid rises after the item carrying last_word passes the input and result registers.
// Throughput: one dword per cycle while the result is not stalled; the input register,
// one decode step and the result register form the path. A stalled result holds the
// decode step, and the input stalls in the same cycle once the input register is occupied.
// Reset (synchronous, active low): 3-byte addressing, zero density, 64 KiB erase
// block with opcode D8h, no candidate sector, enter-4-byte mode 0, both valids low.
module sfdp_basic_table_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_table_id,
    input  logic [7:0]  i_table_version_major,
    input  logic [7:0]  i_table_version_minor,
    input  logic [7:0]  i_table_length_dw,
    input  logic [3:0]  i_dword_position,
    input  logic [31:0] i_table_word,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_parse_status,
    output logic [2:0]  o_address_bytes,
    output logic [31:0] o_density_bytes,
    output logic [16:0] o_block_size_bytes,
    output logic [31:0] o_block_count,
    output logic [7:0]  o_erase_opcode,
    output logic [7:0]  o_four_byte_entry_mode
);

    // Input register: holds one item until the decode step takes it.
    logic              r_in_valid;
    sfdp_pkg::t_item   r_item;

    // Decoder state, updated once per decoded dword.
    sfdp_pkg::t_state  r_state;
    sfdp_pkg::t_state  n_state;
    sfdp_pkg::t_status dec_status;

    // Result register.
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [2:0]        r_addr_len;
    logic [31:0]       r_density;
    logic [16:0]       r_block_size;
    logic [31:0]       r_block_count;
    logic [7:0]        r_erase_op;
    logic [7:0]        r_entry_mode;

    logic                        advance;
    logic [sfdp_pkg::BLK_W-1:0]  n_block_size;

    // Advance the decode step whenever the result register is free or draining.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item.table_id   <= i_table_id;
            r_item.ver_major  <= i_table_version_major;
            r_item.ver_minor  <= i_table_version_minor;
            r_item.len_dwords <= i_table_length_dw;
            r_item.position   <= i_dword_position;
            r_item.word       <= i_table_word;
            r_item.last       <= i_last_word;
        end
    end

    sfdp_word_decode u_decode (
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_status (dec_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.addr_len   <= sfdp_pkg::ADDR_3BYTE;
            r_state.capacity   <= '0;
            r_state.erase_exp  <= sfdp_pkg::EXP_W'(sfdp_pkg::DEFAULT_LOG2);
            r_state.erase_op   <= sfdp_pkg::DEFAULT_OPCODE;
            r_state.best_exp   <= '0;
            r_state.best_op    <= '0;
            r_state.entry_mode <= '0;
        end else if (advance && r_in_valid) begin
            r_state <= n_state;
        end
    end

    // Erase sizes are powers of two: the block count is a right shift.
    assign n_block_size = sfdp_pkg::BLK_W'(1) << n_state.erase_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && r_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && r_item.last) begin
            r_status      <= dec_status;
            r_addr_len    <= n_state.addr_len;
            r_density     <= n_state.capacity;
            r_block_size  <= n_block_size;
            r_block_count <= n_state.capacity >> n_state.erase_exp;
            r_erase_op    <= n_state.erase_op;
            r_entry_mode  <= n_state.entry_mode;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_parse_status         = r_status;
    assign o_address_bytes        = r_addr_len;
    assign o_density_bytes        = r_density;
    assign o_block_size_bytes     = r_block_size;
    assign o_block_count          = r_block_count;
    assign o_erase_opcode         = r_erase_op;
    assign o_four_byte_entry_mode = r_entry_mode;

endmodule

@@ rtl/sfdp_word_decode.sv @@
// Combinational decode of one table dword into the next decoder state.
module sfdp_word_decode (
    input  sfdp_pkg::t_item  i_item,
    input  sfdp_pkg::t_state i_state,
    output sfdp_pkg::t_state o_state,
    output sfdp_pkg::t_status o_status
);

    logic [30:0]             dens_n;
    logic [32:0]             dens_sum;
    logic [31:0]             dens;
    logic [7:0]              exp_a;
    logic [7:0]              exp_b;
    logic                    basic;
    sfdp_pkg::t_state        s;

    always_comb begin
        dens_n   = i_item.word[30:0];
        dens_sum = {1'b0, i_item.word} + 33'd1;
        if (i_item.word[31]) begin
            if (dens_n < 31'd3) begin
                dens = '0;
            end else if (dens_n >= 31'd35) begin
                dens = '1;
            end else begin
                dens = 32'd1 << 6'(dens_n[5:0] - 6'd3);
            end
        end else begin
            dens = 32'(dens_sum[32:3]);
        end
    end

    always_comb begin
        s        = i_state;
        basic    = (i_item.table_id == sfdp_pkg::ID_BASIC);
        exp_a    = i_item.word[7:0];
        exp_b    = i_item.word[23:16];
        o_status = sfdp_pkg::ST_UNKNOWN;

        if (basic) begin
            if (i_item.position == sfdp_pkg::POS_ADDR_MODE) begin
                unique case (i_item.word[18:17])
                    sfdp_pkg::AM_3ONLY, sfdp_pkg::AM_3OR4: s.addr_len = sfdp_pkg::ADDR_3BYTE;
                    sfdp_pkg::AM_4ONLY:                    s.addr_len = sfdp_pkg::ADDR_4BYTE;
                    default:                               s.addr_len = i_state.addr_len;
                endcase
            end else if (i_item.position == sfdp_pkg::POS_DENSITY) begin
                s.capacity = dens;
                if (dens > sfdp_pkg::SIZE_16MIB) begin
                    s.addr_len = sfdp_pkg::ADDR_4BYTE;
                end
            end else if ((i_item.position == sfdp_pkg::POS_SECTOR_LO ||
                          i_item.position == sfdp_pkg::POS_SECTOR_HI) &&
                         i_item.len_dwords >= sfdp_pkg::LEN_SECTORS) begin
                // Strictly larger replaces, so the earlier entry wins a tie.
                if (exp_a != 8'd0 && exp_a <= 8'(sfdp_pkg::MAX_ERASE_LOG2) &&
                    exp_a[sfdp_pkg::EXP_W-1:0] > s.best_exp) begin
                    s.best_exp = exp_a[sfdp_pkg::EXP_W-1:0];
                    s.best_op  = i_item.word[15:8];
                end
                if (exp_b != 8'd0 && exp_b <= 8'(sfdp_pkg::MAX_ERASE_LOG2) &&
                    exp_b[sfdp_pkg::EXP_W-1:0] > s.best_exp) begin
                    s.best_exp = exp_b[sfdp_pkg::EXP_W-1:0];
                    s.best_op  = i_item.word[31:24];
                end
            end else if (i_item.position == sfdp_pkg::POS_ENTER_4B &&
                         i_item.len_dwords >= sfdp_pkg::LEN_ENTER_4B &&
                         i_item.ver_major == sfdp_pkg::VER_MAJOR_1 &&
                         i_item.ver_minor >= sfdp_pkg::VER_MINOR_4B) begin
                s.entry_mode = i_item.word[31:24];
            end
        end

        if (basic) begin
            o_status = (s.best_exp != '0) ? sfdp_pkg::ST_SECTOR : sfdp_pkg::ST_NO_SECTOR;
        end else if (i_item.table_id == sfdp_pkg::ID_FOURBYTE) begin
            o_status = sfdp_pkg::ST_FOURBYTE;
        end

        // Commit the chosen sector and drop the candidate at the end of a table.
        if (i_item.last) begin
            if (basic && s.best_exp != '0) begin
                s.erase_exp = s.best_exp;
                s.erase_op  = s.best_op;
            end
            s.best_exp = '0;
            s.best_op  = '0;
        end

        o_state = s;
    end

endmodule
